[rtl/core/cic_pkg.sv]
`default_nettype none

package cic_pkg;

	typedef enum logic [2:0] {
		OP_READ_EN       = 3'd0,
		OP_READ_REQ      = 3'd1,
		OP_WRITE_EN      = 3'd2,
		OP_WRITE_REQ     = 3'd3,
		OP_WRITE_REQ_DLY = 3'd4,
		OP_TICK          = 3'd5,
		OP_REEVAL        = 3'd6
	} cic_op_t;

	localparam int unsigned MASK_W       = 15;
	localparam int unsigned MASTER_BIT   = 14;
	localparam int unsigned SET_MODE_BIT = 15;
	localparam int unsigned TOP_SOURCE   = 13;
	localparam logic [MASK_W-1:0] CIA_MASK      = 15'h2008;
	localparam logic [7:0]        LATENCY_RESET = 8'd10;
	localparam logic [2:0]        LEVEL_MAX     = 3'd7;

	typedef struct packed {
		logic [MASK_W-1:0] enable_mask;
		logic [MASK_W-1:0] request_mask;
		logic              delay_active;
		logic [7:0]        delay_count;
	} cic_state_t;

	typedef struct packed {
		logic [MASK_W-1:0] read_data;
		logic              irq_raise;
		logic [2:0]        irq_level;
		logic [3:0]        irq_source;
		logic              delay_armed;
		logic              cia_recheck;
	} cic_result_t;

	typedef struct packed {
		logic       found;
		logic [3:0] source;
		logic [2:0] level;
	} cic_prio_t;

	// Fixed map from chip interrupt source to CPU level.
	function automatic logic [2:0] source_level(input logic [3:0] src);
		logic [2:0] lvl;
		unique case (src)
			4'd0, 4'd1, 4'd2:          lvl = 3'd1;
			4'd3:                      lvl = 3'd2;
			4'd4, 4'd5, 4'd6:          lvl = 3'd3;
			4'd7, 4'd8, 4'd9, 4'd10:   lvl = 3'd4;
			4'd11, 4'd12:              lvl = 3'd5;
			4'd13, 4'd14:              lvl = 3'd6;
			default:                   lvl = 3'd7;
		endcase
		return lvl;
	endfunction

endpackage

`default_nettype wire

[rtl/core/cic_prio.sv]
`default_nettype none

module cic_prio
	import cic_pkg::*;
(
	input  wire logic [MASK_W-1:0] pending,
	output cic_prio_t              prio
);

	// Highest pending source among 13..0 wins; bit 14 is the master enable.
	always_comb begin
		prio = '0;
		for (int n = 0; n <= TOP_SOURCE; n++) begin
			if (pending[n]) begin
				prio.found  = 1'b1;
				prio.source = 4'(n);
			end
		end
		prio.level = source_level(prio.source);
	end

endmodule

`default_nettype wire

[rtl/core/cic_eval.sv]
`default_nettype none

module cic_eval
	import cic_pkg::*;
(
	input  wire cic_state_t  state_cur,
	input  wire logic [7:0]  latency,
	input  wire logic [2:0]  opcode,
	input  wire logic [15:0] data,
	input  wire logic [2:0]  cpu_level,
	input  wire logic        cpu_switch_pending,
	input  wire logic        cpu_stopped,
	output cic_state_t       state_nxt,
	output cic_result_t      result
);

	cic_state_t        st_pre;
	cic_result_t       res_pre;
	logic              do_eval;
	logic              delayed;
	logic [MASK_W-1:0] pending;
	cic_prio_t         prio;

	// Register access phase: read or update the masks, step the countdown on a tick, and decide whether to evaluate.
	always_comb begin
		st_pre  = state_cur;
		res_pre = '0;
		do_eval = 1'b0;
		delayed = 1'b0;
		unique case (cic_op_t'(opcode))
			OP_READ_EN:  res_pre.read_data = state_cur.enable_mask;
			OP_READ_REQ: res_pre.read_data = state_cur.request_mask;
			OP_WRITE_EN: begin
				if (data[SET_MODE_BIT]) begin
					st_pre.enable_mask = state_cur.enable_mask | data[MASK_W-1:0];
				end else begin
					st_pre.enable_mask = state_cur.enable_mask & ~data[MASK_W-1:0];
				end
				do_eval = st_pre.enable_mask[MASTER_BIT];
			end
			OP_WRITE_REQ, OP_WRITE_REQ_DLY: begin
				if (data[SET_MODE_BIT]) begin
					st_pre.request_mask = state_cur.request_mask | data[MASK_W-1:0];
					do_eval = 1'b1;
					delayed = (cic_op_t'(opcode) == OP_WRITE_REQ_DLY);
				end else begin
					st_pre.request_mask = state_cur.request_mask & ~data[MASK_W-1:0];
					res_pre.cia_recheck = |(data[MASK_W-1:0] & CIA_MASK);
				end
			end
			OP_TICK: begin
				if (state_cur.delay_active) begin
					if (state_cur.delay_count <= 8'd1) begin
						st_pre.delay_count  = '0;
						st_pre.delay_active = 1'b0;
						do_eval = 1'b1;
					end else begin
						st_pre.delay_count = state_cur.delay_count - 8'd1;
					end
				end
			end
			OP_REEVAL: do_eval = 1'b1;
			default: ;
		endcase
	end

	assign pending = st_pre.enable_mask & st_pre.request_mask;

	cic_prio u_prio (
		.pending (pending),
		.prio    (prio)
	);

	// Evaluation phase: raise, arm the countdown, or hold.
	always_comb begin
		state_nxt = st_pre;
		result    = res_pre;
		if (do_eval && st_pre.enable_mask[MASTER_BIT] && (|pending) && !cpu_switch_pending
				&& !(st_pre.delay_active && delayed)) begin
			// An immediate evaluation cancels a running countdown.
			if (st_pre.delay_active) begin
				state_nxt.delay_active = 1'b0;
				state_nxt.delay_count  = '0;
			end
			if (cpu_level != LEVEL_MAX && prio.found && prio.level > cpu_level) begin
				if (delayed && !cpu_stopped) begin
					state_nxt.delay_active = 1'b1;
					state_nxt.delay_count  = latency;
				end else begin
					result.irq_raise  = 1'b1;
					result.irq_level  = prio.level;
					result.irq_source = prio.source;
				end
			end
		end
		result.delay_armed = state_nxt.delay_active;
	end

endmodule

`default_nettype wire

[rtl/core/chipset_interrupt_controller.sv]
// Pipeline: an accepted transaction moves from the input stage into the result
//   register when that register is empty or its result is being taken.
// Throughput: one transaction per cycle unless the output stalls; the mask and
//   countdown state updates as each enters the result register; the next sees it.
// Reset (arst_n low, asynchronous): both masks and the countdown clear, the
//   latency register returns to LATENCY_RESET, and both pipeline stages go empty.
`default_nettype none

module chipset_interrupt_controller
	import cic_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	// Configuration: raise latency register
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_wdata,

	// Input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        opcode,
	input  wire logic [15:0]       data,
	input  wire logic [2:0]        cpu_level,
	input  wire logic              cpu_switch_pending,
	input  wire logic              cpu_stopped,

	// Result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [MASK_W-1:0]      read_data,
	output logic                   irq_raise,
	output logic [2:0]             irq_level,
	output logic [3:0]             irq_source,
	output logic                   delay_armed,
	output logic                   cia_recheck
);

	// Input stage
	logic        valid_s1;
	logic [2:0]  opcode_s1;
	logic [15:0] data_s1;
	logic [2:0]  cpu_level_s1;
	logic        switch_s1;
	logic        stopped_s1;

	// Architectural state and configuration
	cic_state_t  state_q;
	cic_state_t  state_nxt;
	logic [7:0]  latency_q;

	// Result stage
	logic        out_valid_q;
	cic_result_t result_q;
	cic_result_t result_nxt;

	logic        advance;
	logic        load_s1;

	// Move the input stage forward whenever the result register is empty or
	// its transaction is being taken this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	// Stall the input side only when the input stage holds a transaction
	// that cannot move on.
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload; it holds while the stage is stalled.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			opcode_s1    <= opcode;
			data_s1      <= data;
			cpu_level_s1 <= cpu_level;
			switch_s1    <= cpu_switch_pending;
			stopped_s1   <= cpu_stopped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latency_q <= LATENCY_RESET;
		end else if (cfg_we) begin
			latency_q <= cfg_wdata;
		end
	end

	cic_eval u_eval (
		.state_cur          (state_q),
		.latency            (latency_q),
		.opcode             (opcode_s1),
		.data               (data_s1),
		.cpu_level          (cpu_level_s1),
		.cpu_switch_pending (switch_s1),
		.cpu_stopped        (stopped_s1),
		.state_nxt          (state_nxt),
		.result             (result_nxt)
	);

	// Commit the new state together with the result of the same transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = result_q.read_data;
	assign irq_raise   = result_q.irq_raise;
	assign irq_level   = result_q.irq_level;
	assign irq_source  = result_q.irq_source;
	assign delay_armed = result_q.delay_armed;
	assign cia_recheck = result_q.cia_recheck;

	// An idle countdown always rests at zero.
	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.delay_active |-> state_q.delay_count == '0)
		else $error("countdown idle with nonzero count");

	// A raised level is never zero and the source is a real one.
	a_raise_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.irq_raise
			|-> result_q.irq_level != '0 && result_q.irq_source <= 4'(TOP_SOURCE))
		else $error("raise with bad level or source");

	// Without a raise the level and source fields stay zero.
	a_no_raise_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.irq_raise
			|-> result_q.irq_level == '0 && result_q.irq_source == '0)
		else $error("level or source set without raise");

	// The input side stalls only behind a held transaction in the input stage.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without cause");

	// The armed flag in the result matches the committed countdown state.
	a_armed_matches: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_q.delay_armed == state_q.delay_active)
		else $error("delay_armed disagrees with countdown state");

endmodule

`default_nettype wire
